// ----- hw/rtl/bmtc_pkg.sv -----
package bmtc_pkg;

  // Matrix size: ROWS member nodes by COLS owner nodes
  localparam int ROWS = 32;
  localparam int COLS = 32;

  localparam int NODE_W   = 6;
  localparam int FUNC_W   = 2;
  localparam int CHILD_W  = 5;
  localparam int MAX_LIST = 32;

  localparam int ROW_IW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_IW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int LIST_ROWS = (ROWS < MAX_LIST) ? ROWS : MAX_LIST;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_LIST  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_SET_OK,
    RES_REJECT,
    RES_QUERY,
    RES_CHILD,
    RES_EMPTY
  } res_e;

  typedef struct packed {
    logic load_in;
    logic set_base;
    logic col_y_or;
    logic walk_step;
    logic load_list;
    logic push;
    res_e kind;
  } bmtc_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              closure;
    logic              set_reject;
    logic              walk_last;
    logic              list_empty;
    logic              list_one;
    logic              slot_free;
  } bmtc_stat_t;

endpackage

// ----- hw/rtl/bmtc_ctrl.sv -----
module bmtc_ctrl
  import bmtc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  bmtc_stat_t stat_i,
  output bmtc_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COLY,
    ST_WALK,
    ST_EMIT,
    ST_LIST
  } state_e;

  state_e state_q, state_d;
  res_e   kind_q, kind_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.kind = RES_ZERO;
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.func)
          FUNC_SET: begin
            if (stat_i.set_reject) begin
              kind_d  = RES_REJECT;
              state_d = ST_EMIT;
            end else begin
              cmd_o.set_base = 1'b1;
              if (stat_i.closure) begin
                state_d = ST_COLY;
              end else begin
                kind_d  = RES_SET_OK;
                state_d = ST_EMIT;
              end
            end
          end
          FUNC_QUERY: begin
            kind_d  = RES_QUERY;
            state_d = ST_EMIT;
          end
          FUNC_LIST: begin
            cmd_o.load_list = 1'b1;
            state_d         = ST_LIST;
          end
          default: begin
            kind_d  = RES_ZERO;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_COLY: begin
        // members of x join column y; also restarts the column walk
        cmd_o.col_y_or = 1'b1;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          kind_d  = RES_SET_OK;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.kind = kind_q;
        if (stat_i.slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_LIST: begin
        cmd_o.kind = stat_i.list_empty ? RES_EMPTY : RES_CHILD;
        if (stat_i.slot_free) begin
          cmd_o.push = 1'b1;
          if (stat_i.list_empty || stat_i.list_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= RES_ZERO;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

// ----- hw/rtl/bmtc_dp.sv -----
module bmtc_dp
  import bmtc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [NODE_W-1:0]     row_node_i,
  input  logic [NODE_W-1:0]     col_node_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_data_i,
  input  bmtc_cmd_t             cmd_i,
  output bmtc_stat_t            stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  belongs_o,
  output logic                  rejected_o,
  output logic [CHILD_W-1:0]    child_index_o,
  output logic                  none_found_o,
  output logic                  last_o
);

  logic [COLS-1:0]     rel_q [ROWS];
  logic [COLS-1:0]     rel_d [ROWS];
  logic                closure_q;
  logic [FUNC_W-1:0]   func_q;
  logic [NODE_W-1:0]   x_q, y_q;
  logic [COL_IW-1:0]   walk_q, walk_d;
  logic [MAX_LIST-1:0] list_q, list_d, list_vec, low_oh;
  logic [CHILD_W-1:0]  low_idx;

  logic                out_valid_q;
  logic                bel_q, rej_q, none_q, last_q;
  logic [CHILD_W-1:0]  child_q;
  logic                bel_d, rej_d, none_d, last_d;
  logic [CHILD_W-1:0]  child_d;

  logic                x_in_rows, x_in_cols, y_in_rows, y_in_cols;
  logic [ROW_IW-1:0]   xr, yr;
  logic [COL_IW-1:0]   xc, yc;
  logic [ROWS-1:0]     colx, coly, coli;
  logic                cyc_hit, belongs, walk_hit, slot_free;

  assign x_in_rows = {1'b0, x_q} < (NODE_W+1)'(ROWS);
  assign x_in_cols = {1'b0, x_q} < (NODE_W+1)'(COLS);
  assign y_in_rows = {1'b0, y_q} < (NODE_W+1)'(ROWS);
  assign y_in_cols = {1'b0, y_q} < (NODE_W+1)'(COLS);
  assign xr = x_q[ROW_IW-1:0];
  assign yr = y_q[ROW_IW-1:0];
  assign xc = x_q[COL_IW-1:0];
  assign yc = y_q[COL_IW-1:0];

  // column x, column y and the walked column, one bit per row
  always_comb begin
    for (int j = 0; j < ROWS; j++) begin
      colx[j] = x_in_cols && rel_q[j][xc];
      coly[j] = y_in_cols && rel_q[j][yc];
      coli[j] = rel_q[j][walk_q];
    end
  end

  assign cyc_hit  = y_in_rows && colx[yr];
  assign belongs  = x_in_rows && coly[xr];
  assign walk_hit = y_in_rows && coli[yr];

  always_comb begin
    list_vec = '0;
    for (int r = 0; r < LIST_ROWS; r++) begin
      list_vec[r] = coly[r];
    end
  end

  // lowest pending member of the list
  assign low_oh = list_q & (~list_q + MAX_LIST'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MAX_LIST; i++) begin
      if (low_oh[i]) begin
        low_idx = low_idx | CHILD_W'(i);
      end
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.func       = func_q;
    stat_o.closure    = closure_q;
    stat_o.set_reject = !x_in_rows || !y_in_cols || (closure_q && cyc_hit);
    stat_o.walk_last  = (walk_q == COL_IW'(COLS - 1));
    stat_o.list_empty = (list_q == '0);
    stat_o.list_one   = (list_q != '0) && ((list_q & (list_q - MAX_LIST'(1))) == '0);
    stat_o.slot_free  = slot_free;
  end

  // matrix update
  always_comb begin
    rel_d = rel_q;
    if (cmd_i.set_base && x_in_rows && y_in_cols) begin
      rel_d[xr][yc] = 1'b1;
      if (closure_q && x_in_cols) begin
        rel_d[xr][xc] = 1'b1;
      end
    end
    if (cmd_i.col_y_or && y_in_cols) begin
      for (int j = 0; j < ROWS; j++) begin
        if (colx[j]) begin
          rel_d[j][yc] = 1'b1;
        end
      end
    end
    if (cmd_i.walk_step && walk_hit) begin
      for (int j = 0; j < ROWS; j++) begin
        if (colx[j]) begin
          rel_d[j][walk_q] = 1'b1;
        end
      end
      if (x_in_rows) begin
        rel_d[xr][walk_q] = 1'b1;
      end
    end
  end

  always_comb begin
    walk_d = walk_q;
    if (cmd_i.col_y_or) begin
      walk_d = '0;
    end else if (cmd_i.walk_step) begin
      walk_d = walk_q + COL_IW'(1);
    end
  end

  always_comb begin
    list_d = list_q;
    if (cmd_i.load_list) begin
      list_d = list_vec;
    end else if (cmd_i.push && cmd_i.kind == RES_CHILD) begin
      list_d = list_q & ~low_oh;
    end
  end

  always_comb begin
    bel_d   = 1'b0;
    rej_d   = 1'b0;
    child_d = '0;
    none_d  = 1'b0;
    last_d  = 1'b1;
    case (cmd_i.kind)
      RES_REJECT: rej_d = 1'b1;
      RES_QUERY:  bel_d = belongs;
      RES_CHILD: begin
        child_d = low_idx;
        last_d  = stat_o.list_one;
      end
      RES_EMPTY:  none_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ROWS; j++) begin
        rel_q[j] <= '0;
      end
      closure_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      rel_q <= rel_d;
      if (cfg_valid_i) begin
        closure_q <= cfg_data_i;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      x_q    <= row_node_i;
      y_q    <= col_node_i;
    end
    walk_q <= walk_d;
    list_q <= list_d;
    if (cmd_i.push) begin
      bel_q   <= bel_d;
      rej_q   <= rej_d;
      child_q <= child_d;
      none_q  <= none_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign belongs_o     = bel_q;
  assign rejected_o    = rej_q;
  assign child_index_o = child_q;
  assign none_found_o  = none_q;
  assign last_o        = last_q;

endmodule

// ----- hw/rtl/bit_matrix_transitive_closure.sv -----
// Membership bit matrix (32 member rows by 32 owner columns) with set, query
// and list operations, and a closure mode (on after reset) that keeps the
// relation reflexive and transitively closed on every set. Each operation is
// one input transaction; set and query give one result, a list gives one
// result per member row in ascending order (or one none_found result), the
// final one marked by tlast. Items are handled one at a time. A query, a
// plain set, a rejected set or an unused code passes through decode and then
// the emit state; a list is decoded and then gives one result per cycle
// while the output does not stall; a closure set goes through decode, a step
// that adds the members of x to column y, then the column walk across all
// columns that updates one column per cycle across all rows in parallel,
// then the emit state. A new transaction is taken as soon as the previous
// result is loaded into the output register, even while that result still
// waits for tready. Write closure_mode only while the block is idle.
module bit_matrix_transitive_closure
  import bmtc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // row_node[5:0], col_node[11:6], zero pad
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // belongs[0], rejected[1], child_index[6:2], 0
  output logic [0:0]            m_axis_tuser,   // none_found[0]
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i      // closure_mode
);

  bmtc_cmd_t          cmd;
  bmtc_stat_t         stat;
  logic               belongs, rejected, none_found;
  logic [CHILD_W-1:0] child_index;

  assign cfg_ready_o = 1'b1;

  bmtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bmtc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (s_axis_tuser),
    .row_node_i    (s_axis_tdata[NODE_W-1:0]),
    .col_node_i    (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .belongs_o     (belongs),
    .rejected_o    (rejected),
    .child_index_o (child_index),
    .none_found_o  (none_found),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, child_index, rejected, belongs};
  assign m_axis_tuser = none_found;

  // one operation in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an operation is in progress");

  // an empty list is a single all-zero result
  a_empty_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("none_found result not alone or carries data");

  // set and query answers with belongs or rejected set always close their operation
  a_single_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1])) |-> m_axis_tlast)
    else $error("set or query result without tlast");

endmodule
